### hdl/relay_pattern_sequencer_top_macros.svh
// Assertion macros for the relay pattern sequencer.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef RELAY_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define RELAY_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rps_pkg.sv
// Package of the relay pattern sequencer: relay counts, masks, mode and
// command codes and the pattern table. Depends on nothing.
`default_nettype none

package rps_pkg;

  // Relay line counts.
  localparam int RELAY_COUNT     = 16;
  localparam int LED_RELAY_COUNT = 12;
  localparam int RELAY_W         = 16;
  localparam int POS_W           = 5;

  // Mask of the low n lines, saturating at the port width.
  function automatic logic [RELAY_W-1:0] low_mask(input int n);
    logic [RELAY_W-1:0] m;
    m = '0;
    for (int i = 0; i < RELAY_W; i++) begin
      if (i < n) m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [RELAY_W-1:0] RELAY_MASK = low_mask(RELAY_COUNT);
  localparam logic [RELAY_W-1:0] LED_MASK   = low_mask(LED_RELAY_COUNT) & RELAY_MASK;

  // Chaser positions: the last LED relay, and the wrapped position below zero.
  localparam logic [POS_W-1:0] LED_LAST  = POS_W'(LED_RELAY_COUNT - 1);
  localparam logic [POS_W-1:0] POS_BELOW = '1;

  // Command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_APPLY = 1'b1;

  // Operating modes.
  localparam logic [1:0] MODE_MANUAL  = 2'd0;
  localparam logic [1:0] MODE_SERIAL  = 2'd1;
  localparam logic [1:0] MODE_RANDOM  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // Pattern rows of the random mode, one per combination.
  localparam logic [RELAY_W-1:0] PATTERN_ROWS [4] = '{
    16'h5555, 16'h3333, 16'h0F0F, 16'h003F
  };

endpackage

`default_nettype wire

### hdl/relay_pattern_sequencer_top.sv
// Relay pattern sequencer: one item per cycle while results are taken, input register then state/result registers.
// Depends on rps_pkg and relay_pattern_sequencer_top_macros.svh.
`default_nettype none
`include "relay_pattern_sequencer_top_macros.svh"

// Each word is a one-second tick or an apply of new settings, and each one
// produces exactly one result word carrying the relay levels, the status
// flags and the active mode after that word took effect. A word passes an
// input register and then updates the state registers, which also serve as
// the result register, and a new word can be taken in every cycle while
// results are taken. While a result waits for out_ready_i, the input
// register still takes one more word.
module relay_pattern_sequencer_top
  import rps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [RELAY_W-1:0] manual_levels_i,
  input  wire logic               serial_request_i,
  input  wire logic [2:0]         random_select_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [RELAY_W-1:0] relay_levels_o,
  output      logic [RELAY_W-1:0] relay_ok_mask_o,
  output      logic               serial_ok_o,
  output      logic               random_ok_o,
  output      logic [1:0]         mode_now_o
);

  // Input register.
  logic               in_valid_q;
  logic               cmd_q;
  logic [RELAY_W-1:0] manual_q;
  logic               ser_q;
  logic [2:0]         rnd_q;

  // State, which is also the result.
  logic               out_valid_q;
  logic [RELAY_W-1:0] levels_q, levels_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               fwd_q, fwd_d;
  logic [3:0]         sec_q, sec_d;
  logic [1:0]         comb_q, comb_d;
  logic [1:0]         mode_q, mode_d;
  logic [RELAY_W-1:0] ok_mask_q, ok_mask_d;
  logic               serial_ok_q, serial_ok_d;
  logic               random_ok_q, random_ok_d;

  logic               advance;
  logic               fire;
  logic [RELAY_W-1:0] row;
  logic [POS_W-1:0]   pos_tmp;
  logic               fwd_tmp;
  logic [2:0]         rnd_m1;

  // Handshake: the input stage moves on when the result slot is free.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      manual_q <= manual_levels_i;
      ser_q    <= serial_request_i;
      rnd_q    <= random_select_i;
    end
  end

  // Next state for the word in the input register.
  always_comb begin
    levels_d    = levels_q;
    pos_d       = pos_q;
    fwd_d       = fwd_q;
    sec_d       = sec_q;
    comb_d      = comb_q;
    mode_d      = mode_q;
    ok_mask_d   = ok_mask_q;
    serial_ok_d = serial_ok_q;
    random_ok_d = random_ok_q;
    pos_tmp     = pos_q;
    fwd_tmp     = fwd_q;
    rnd_m1      = rnd_q - 3'd1;
    row         = PATTERN_ROWS[comb_q];

    if (cmd_q == CMD_APPLY) begin
      if (!ser_q && rnd_q == 3'd0) begin
        // Manual mode: copy the levels and mark every relay updated.
        levels_d    = (manual_q & RELAY_MASK) | ~RELAY_MASK;
        ok_mask_d   = RELAY_MASK;
        serial_ok_d = 1'b0;
        random_ok_d = 1'b0;
        mode_d      = MODE_MANUAL;
      end else begin
        // Pattern or invalid request: turn the LED relays off first.
        levels_d    = levels_q | LED_MASK;
        ok_mask_d   = '0;
        serial_ok_d = 1'b0;
        random_ok_d = 1'b0;
        if (ser_q && rnd_q == 3'd0) begin
          serial_ok_d = 1'b1;
          mode_d      = MODE_SERIAL;
        end else if (!ser_q) begin
          random_ok_d = 1'b1;
          comb_d      = rnd_m1[1:0];
          mode_d      = MODE_RANDOM;
        end else begin
          mode_d = MODE_INVALID;
        end
      end
    end else if (mode_q == MODE_SERIAL) begin
      // Bouncing fill chaser: turn around at either end.
      if (pos_q > LED_LAST) begin
        fwd_tmp = ~fwd_q;
        if (pos_q == POS_BELOW) begin
          pos_tmp  = '0;
          levels_d = levels_q | (LED_MASK & ~RELAY_W'(1));
        end else begin
          pos_tmp  = LED_LAST;
          levels_d = levels_q | (LED_MASK & ~(RELAY_W'(1) << LED_LAST[3:0]));
        end
      end else begin
        levels_d = (levels_q & ~(RELAY_W'(1) << pos_q[3:0])) | ~RELAY_MASK;
      end
      fwd_d = fwd_tmp;
      pos_d = fwd_tmp ? pos_tmp + POS_W'(1) : pos_tmp - POS_W'(1);
    end else if (mode_q == MODE_RANDOM) begin
      // Pattern row, inverted in the second half of each eight seconds.
      if (sec_q[2]) begin
        row = ~row;
      end
      levels_d = (levels_q & ~LED_MASK) | (row & LED_MASK);
      sec_d    = sec_q + 4'd1;
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q    <= '1;
      pos_q       <= '0;
      fwd_q       <= 1'b1;
      sec_q       <= '0;
      comb_q      <= '0;
      mode_q      <= MODE_MANUAL;
      ok_mask_q   <= '0;
      serial_ok_q <= 1'b0;
      random_ok_q <= 1'b0;
    end else if (fire) begin
      levels_q    <= levels_d;
      pos_q       <= pos_d;
      fwd_q       <= fwd_d;
      sec_q       <= sec_d;
      comb_q      <= comb_d;
      mode_q      <= mode_d;
      ok_mask_q   <= ok_mask_d;
      serial_ok_q <= serial_ok_d;
      random_ok_q <= random_ok_d;
    end
  end

  // Result ports.
  assign out_valid_o     = out_valid_q;
  assign relay_levels_o  = levels_q;
  assign relay_ok_mask_o = ok_mask_q;
  assign serial_ok_o     = serial_ok_q;
  assign random_ok_o     = random_ok_q;
  assign mode_now_o      = mode_q;

  // Checks on the internal state.
  `RPS_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q, "input word dropped")
  `RPS_ASSERT_NOW(a_ok_mask_manual, mode_q != MODE_MANUAL, ok_mask_q == '0, "ok mask outside manual")
  `RPS_ASSERT_NOW(a_flags_mode, serial_ok_q || random_ok_q, (serial_ok_q && mode_q == MODE_SERIAL) || (random_ok_q && mode_q == MODE_RANDOM), "flag and mode disagree")
  `RPS_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_W'(LED_RELAY_COUNT) || pos_q == POS_BELOW, "chaser position out of range")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench of the relay pattern sequencer: a directed table, then
// random apply and tick sequences, all checked against a cycle-free predictor.
// Depends on rps_pkg and the relay_pattern_sequencer_top RTL.
`timescale 1ns / 100ps

module testbench;
  import rps_pkg::*;

  // One input word and one result word as the ports see them.
  typedef struct packed {
    logic               cmd;
    logic [RELAY_W-1:0] levels;
    logic               serial_req;
    logic [2:0]         rand_sel;
  } word_t;

  typedef struct packed {
    logic [RELAY_W-1:0] levels;
    logic [RELAY_W-1:0] ok_mask;
    logic               serial_ok;
    logic               random_ok;
    logic [1:0]         mode;
  } status_t;

  // A row of the directed table; typed rows carry their own expected status.
  typedef struct {
    word_t   w;
    bit      typed;
    status_t s;
  } plan_row_t;

  localparam status_t NO_STATUS   = '0;
  localparam int      HOLD_CYCLES = 200;
  localparam int      STALL_LIMIT = 2000;
  localparam int      WORD_TARGET = 1250;
  localparam int      DRAIN_WAIT  = 10;
  localparam int      ERR_PRINTS  = 20;

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               cmd_i            = CMD_TICK;
  logic [RELAY_W-1:0] manual_levels_i  = '0;
  logic               serial_request_i = 1'b0;
  logic [2:0]         random_select_i  = '0;
  logic               out_ready_i      = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [RELAY_W-1:0] relay_levels_o;
  logic [RELAY_W-1:0] relay_ok_mask_o;
  logic               serial_ok_o;
  logic               random_ok_o;
  logic [1:0]         mode_now_o;

  relay_pattern_sequencer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .manual_levels_i  (manual_levels_i),
    .serial_request_i (serial_request_i),
    .random_select_i  (random_select_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .relay_levels_o   (relay_levels_o),
    .relay_ok_mask_o  (relay_ok_mask_o),
    .serial_ok_o      (serial_ok_o),
    .random_ok_o      (random_ok_o),
    .mode_now_o       (mode_now_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted sequencer state, kept at reset values until the first word.
  logic [RELAY_W-1:0] pred_levels = '1;
  logic [POS_W-1:0]   chase_pos   = '0;
  logic               chase_fwd   = 1'b1;
  logic [3:0]         sec_cnt     = '0;
  logic [1:0]         comb_sel    = '0;
  logic [1:0]         cur_mode    = MODE_MANUAL;
  logic [RELAY_W-1:0] ok_mask     = '0;
  logic               serial_flag = 1'b0;
  logic               random_flag = 1'b0;

  status_t pending_status_q[$];
  int      errors      = 0;
  int      words_sent  = 0;
  int      stall_cycles = 0;
  bit      gaps_on     = 1'b1;
  bit      hold_req    = 1'b0;

  // Applies one word to the predicted state and returns the status it reports.
  function automatic status_t step_sequencer(input word_t w);
    status_t            s;
    logic [RELAY_W-1:0] row;
    if (w.cmd == CMD_APPLY) begin
      if (!w.serial_req && w.rand_sel == 3'd0) begin
        pred_levels = (w.levels & RELAY_MASK) | ~RELAY_MASK;
        ok_mask     = RELAY_MASK;
        serial_flag = 1'b0;
        random_flag = 1'b0;
        cur_mode    = MODE_MANUAL;
      end else begin
        ok_mask     = '0;
        serial_flag = 1'b0;
        random_flag = 1'b0;
        pred_levels = pred_levels | LED_MASK;
        if (w.serial_req && w.rand_sel == 3'd0) begin
          serial_flag = 1'b1;
          cur_mode    = MODE_SERIAL;
        end else if (!w.serial_req) begin
          random_flag = 1'b1;
          comb_sel    = 2'(w.rand_sel - 3'd1);
          cur_mode    = MODE_RANDOM;
        end else begin
          cur_mode = MODE_INVALID;
        end
      end
    end else if (cur_mode == MODE_SERIAL) begin
      // Past either end the chaser turns around and clears all but the end relay.
      if (chase_pos > LED_LAST) begin
        chase_fwd = !chase_fwd;
        if (chase_pos == POS_BELOW) begin
          chase_pos   = '0;
          pred_levels = pred_levels | (LED_MASK & ~RELAY_W'(1));
        end else begin
          chase_pos   = LED_LAST;
          pred_levels = pred_levels | (LED_MASK & ~(RELAY_W'(1) << LED_LAST));
        end
      end else begin
        pred_levels = (pred_levels & ~(RELAY_W'(1) << chase_pos[3:0])) | ~RELAY_MASK;
      end
      chase_pos = chase_fwd ? chase_pos + POS_W'(1) : chase_pos - POS_W'(1);
    end else if (cur_mode == MODE_RANDOM) begin
      // The row is inverted on seconds 4-7 and 12-15 of the cycle.
      row = PATTERN_ROWS[comb_sel];
      if (sec_cnt[2]) row = ~row;
      pred_levels = (pred_levels & ~LED_MASK) | (row & LED_MASK);
      sec_cnt     = sec_cnt + 4'd1;
    end
    s.levels    = pred_levels;
    s.ok_mask   = ok_mask;
    s.serial_ok = serial_flag;
    s.random_ok = random_flag;
    s.mode      = cur_mode;
    return s;
  endfunction

  // Offers one word, waits for its handshake and records the expected status.
  task automatic send_word(input word_t w, input bit typed, input status_t typed_s);
    status_t predicted;
    if (gaps_on) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= w.cmd;
    manual_levels_i  <= w.levels;
    serial_request_i <= w.serial_req;
    random_select_i  <= w.rand_sel;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    predicted = step_sequencer(w);
    pending_status_q.push_back(typed ? typed_s : predicted);
  endtask

  function automatic word_t random_tick();
    word_t w;
    w.cmd        = CMD_TICK;
    w.levels     = RELAY_W'($urandom);
    w.serial_req = 1'($urandom);
    w.rand_sel   = 3'($urandom);
    return w;
  endfunction

  function automatic plan_row_t plan_row(input logic c, input logic [RELAY_W-1:0] lv,
                                         input logic sr, input logic [2:0] rs,
                                         input bit typed, input status_t s);
    plan_row_t r;
    r.w     = '{c, lv, sr, rs};
    r.typed = typed;
    r.s     = s;
    return r;
  endfunction

  // Stimulus: reset, directed table, then random sequences.
  initial begin : stimulus
    plan_row_t plan[$];
    word_t     w;
    int        kind;
    int        ticks;
    bit        hold_done;
    hold_done = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, manual extremes, each mode, invalid requests and the select wrap.
    plan.push_back(plan_row(CMD_TICK, 16'h0000, 1'b0, 3'd0, 1'b1,
                            '{16'hFFFF, 16'h0000, 1'b0, 1'b0, MODE_MANUAL}));
    plan.push_back(plan_row(CMD_APPLY, 16'h0000, 1'b0, 3'd0, 1'b1,
                            '{16'h0000, 16'hFFFF, 1'b0, 1'b0, MODE_MANUAL}));
    plan.push_back(plan_row(CMD_APPLY, 16'hFFFF, 1'b0, 3'd0, 1'b1,
                            '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, MODE_MANUAL}));
    plan.push_back(plan_row(CMD_APPLY, 16'hA5C3, 1'b0, 3'd0, 1'b1,
                            '{16'hA5C3, 16'hFFFF, 1'b0, 1'b0, MODE_MANUAL}));
    plan.push_back(plan_row(CMD_TICK, 16'hFFFF, 1'b1, 3'd7, 1'b1,
                            '{16'hA5C3, 16'hFFFF, 1'b0, 1'b0, MODE_MANUAL}));
    plan.push_back(plan_row(CMD_APPLY, 16'h1234, 1'b1, 3'd0, 1'b1,
                            '{16'hAFFF, 16'h0000, 1'b1, 1'b0, MODE_SERIAL}));
    repeat (3) plan.push_back(plan_row(CMD_TICK, 16'h0000, 1'b0, 3'd0, 1'b0, NO_STATUS));
    plan.push_back(plan_row(CMD_APPLY, 16'h0000, 1'b1, 3'd4, 1'b1,
                            '{16'hAFFF, 16'h0000, 1'b0, 1'b0, MODE_INVALID}));
    plan.push_back(plan_row(CMD_TICK, 16'hFFFF, 1'b0, 3'd0, 1'b0, NO_STATUS));
    plan.push_back(plan_row(CMD_APPLY, 16'h0000, 1'b0, 3'd1, 1'b1,
                            '{16'hAFFF, 16'h0000, 1'b0, 1'b1, MODE_RANDOM}));
    plan.push_back(plan_row(CMD_TICK, 16'h0000, 1'b0, 3'd0, 1'b0, NO_STATUS));
    for (int sel = 2; sel <= 7; sel++) begin
      plan.push_back(plan_row(CMD_APPLY, 16'hFFFF, 1'b0, 3'(sel), 1'b0, NO_STATUS));
      plan.push_back(plan_row(CMD_TICK, 16'h0000, 1'b0, 3'd0, 1'b0, NO_STATUS));
    end
    plan.push_back(plan_row(CMD_APPLY, 16'h0000, 1'b1, 3'd6, 1'b0, NO_STATUS));
    plan.push_back(plan_row(CMD_APPLY, 16'h0000, 1'b0, 3'd0, 1'b1,
                            '{16'h0000, 16'hFFFF, 1'b0, 1'b0, MODE_MANUAL}));
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].s);

    // Mostly an apply followed by a run of ticks, with bursts of raw noise.
    while (words_sent < WORD_TARGET) begin
      if (!hold_done && words_sent >= 100) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      gaps_on = !(words_sent >= 500 && words_sent < 800);
      if ($urandom_range(99) < 75) begin
        w.cmd    = CMD_APPLY;
        w.levels = RELAY_W'($urandom);
        kind     = $urandom_range(99);
        if (kind < 20) begin
          w.serial_req = 1'b0;
          w.rand_sel   = 3'd0;
        end else if (kind < 55) begin
          w.serial_req = 1'b1;
          w.rand_sel   = 3'd0;
        end else if (kind < 90) begin
          w.serial_req = 1'b0;
          w.rand_sel   = 3'($urandom_range(1, 7));
        end else begin
          w.serial_req = 1'b1;
          w.rand_sel   = 3'($urandom_range(1, 7));
        end
        send_word(w, 1'b0, NO_STATUS);
        ticks = (kind >= 20 && kind < 90) ? $urandom_range(1, 40) : $urandom_range(0, 3);
        repeat (ticks) send_word(random_tick(), 1'b0, NO_STATUS);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          w            = random_tick();
          w.cmd        = 1'($urandom);
          send_word(w, 1'b0, NO_STATUS);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain the remaining results, then let the pipeline settle.
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off that fills the block.
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= !(gaps_on && $urandom_range(99) < 24);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{relay_levels_o, relay_ok_mask_o, serial_ok_o, random_ok_o, mode_now_o};
      if (pending_status_q.size() == 0) begin
        errors++;
        if (errors <= ERR_PRINTS) begin
          $display("%0t: unexpected result word levels %h mask %h", $time,
                   relay_levels_o, relay_ok_mask_o);
        end
      end else begin
        want = pending_status_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= ERR_PRINTS) begin
            $display("%0t: mismatch exp levels %h mask %h ser %b rnd %b mode %0d",
                     $time, want.levels, want.ok_mask, want.serial_ok, want.random_ok,
                     want.mode);
            $display("%0t:          got levels %h mask %h ser %b rnd %b mode %0d",
                     $time, got.levels, got.ok_mask, got.serial_ok, got.random_ok,
                     got.mode);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without any accepted word ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
